// ===== sv/wbm_pkg.sv =====
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types and constants of the windowed battery monitor.
// ----------------------------------------------------------------------------
package wbm_pkg;

  localparam int unsigned CountWidthDef = 10;
  localparam int unsigned WinW          = 10;
  localparam int unsigned LvlW          = 8;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned InTdataW      = 16;
  localparam int unsigned OutTdataW     = 8;
  localparam int unsigned QueueDepth    = 2;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LEN      = 3'd0,
    REG_SHUTDOWN_LEVEL  = 3'd1,
    REG_WARN_LEVEL      = 3'd2,
    REG_REDUCE_LEVEL    = 3'd3,
    REG_RECOVER_WINDOWS = 3'd4,
    REG_POWERDOWN_DELAY = 3'd5
  } reg_idx_e;

  localparam logic [WinW-1:0] WindowLenRst      = 10'd100;
  localparam logic [LvlW-1:0] ShutdownLevelRst  = 8'd32;
  localparam logic [LvlW-1:0] WarnLevelRst      = 8'd33;
  localparam logic [LvlW-1:0] ReduceLevelRst    = 8'd35;
  localparam logic [LvlW-1:0] RecoverWindowsRst = 8'd5;
  localparam logic [LvlW-1:0] PowerdownDelayRst = 8'd14;

  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_WARNED = 2'd1,
    PH_SHUT   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [WinW-1:0] window_len;
    logic [LvlW-1:0] shutdown_level;
    logic [LvlW-1:0] warn_level;
    logic [LvlW-1:0] reduce_level;
    logic [LvlW-1:0] recover_windows;
    logic [LvlW-1:0] powerdown_delay;
  } cfg_t;

  // classified sample
  typedef struct packed {
    logic queue_ready;
    logic above_reduce;
    logic below_reduce;
    logic below_warn;
    logic below_shut;
  } item_t;

  // result, window_done in bit 0
  typedef struct packed {
    logic supply_reduced;
    logic warning_request;
    logic shutdown_request;
    logic low_power;
    logic window_done;
  } result_t;

endpackage

// ===== sv/wbm_front.sv =====
// ----------------------------------------------------------------------------
// wbm_front
// Compares each sample against the configured levels.
// ----------------------------------------------------------------------------
module wbm_front (
  input  logic [wbm_pkg::LvlW-1:0] battery_level_i,
  input  logic                     queue_ready_i,
  input  wbm_pkg::cfg_t            cfg_i,
  output wbm_pkg::item_t           item_o
);

  always_comb begin
    item_o.below_shut   = battery_level_i < cfg_i.shutdown_level;
    item_o.below_warn   = battery_level_i < cfg_i.warn_level;
    item_o.below_reduce = battery_level_i < cfg_i.reduce_level;
    item_o.above_reduce = battery_level_i > cfg_i.reduce_level;
    item_o.queue_ready  = queue_ready_i;
  end

endmodule

// ===== sv/wbm_queue.sv =====
// ----------------------------------------------------------------------------
// wbm_queue
// Two-entry queue between the classifier and the window engine.
// ----------------------------------------------------------------------------
module wbm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wbm_pkg::item_t push_data_i,
  output logic           not_full_o,
  input  logic           pop_i,
  output wbm_pkg::item_t pop_data_o,
  output logic           not_empty_o
);

  localparam int unsigned PtrW = $clog2(wbm_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(wbm_pkg::QueueDepth + 1);

  wbm_pkg::item_t mem_q [wbm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign not_full_o  = cnt_q != CntW'(wbm_pkg::QueueDepth);
  assign not_empty_o = cnt_q != '0;
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(wbm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(wbm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/wbm_back.sv =====
// ----------------------------------------------------------------------------
// wbm_back
// Window engine: vote counters, request logic, supply hysteresis, output reg.
// ----------------------------------------------------------------------------
module wbm_back #(
  parameter int unsigned COUNT_WIDTH = wbm_pkg::CountWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wbm_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  wbm_pkg::item_t   item_i,
  output logic             item_pop_o,
  output logic             res_valid_o,
  output wbm_pkg::result_t res_o,
  input  logic             res_ready_i
);

  localparam int unsigned CmpW = (COUNT_WIDTH > wbm_pkg::WinW) ? COUNT_WIDTH : wbm_pkg::WinW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, shv_q, shv_d, wnv_q, wnv_d, rdv_q, rdv_d;
  logic [wbm_pkg::LvlW-1:0] rec_q, rec_d, dly_q, dly_d;
  wbm_pkg::phase_e phase_q, phase_d;
  logic sent_q, sent_d, red_q, red_d, low_q, low_d;
  logic res_valid_q;
  wbm_pkg::result_t res_q, res_d;
  logic [CmpW-1:0] half;

  assign item_pop_o  = item_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign half        = CmpW'(cfg_i.window_len[wbm_pkg::WinW-1:1]);

  always_comb begin
    cnt_d   = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
    shv_d   = shv_q;
    wnv_d   = wnv_q;
    rdv_d   = rdv_q;
    rec_d   = rec_q;
    dly_d   = dly_q;
    phase_d = phase_q;
    sent_d  = sent_q;
    red_d   = red_q;
    low_d   = low_q;
    res_d   = '0;
    if (item_i.below_shut && shv_q != CntMax) shv_d = shv_q + 1'b1;
    if (item_i.below_warn && wnv_q != CntMax) wnv_d = wnv_q + 1'b1;
    if (item_i.below_reduce && rdv_q != CntMax) rdv_d = rdv_q + 1'b1;

    if (CmpW'(cnt_d) >= CmpW'(cfg_i.window_len)) begin
      res_d.window_done = 1'b1;

      // warning delay, escalates regardless of earlier requests
      if (phase_q == wbm_pkg::PH_WARNED) begin
        dly_d = (dly_q == '1) ? dly_q : dly_q + 1'b1;
        if (dly_d > cfg_i.powerdown_delay) begin
          phase_d = wbm_pkg::PH_SHUT;
          dly_d   = '0;
          if (item_i.queue_ready) begin
            res_d.shutdown_request = 1'b1;
            sent_d                 = 1'b1;
          end
        end
      end

      if (CmpW'(shv_d) > half) begin
        low_d = 1'b1;
        if (!sent_d) begin
          phase_d = wbm_pkg::PH_SHUT;
          if (item_i.queue_ready) begin
            res_d.shutdown_request = 1'b1;
            sent_d                 = 1'b1;
          end
        end
      end else if (CmpW'(wnv_d) > half) begin
        low_d = 1'b1;
        if (!sent_d) begin
          phase_d = wbm_pkg::PH_WARNED;
          if (item_i.queue_ready) begin
            res_d.warning_request = 1'b1;
            sent_d                = 1'b1;
          end
        end
      end else begin
        low_d = 1'b0;
      end

      // supply mode with hysteresis
      if (CmpW'(rdv_d) > half) begin
        red_d = 1'b1;
        rec_d = '0;
      end else if (item_i.above_reduce) begin
        if (rec_q > cfg_i.recover_windows) begin
          rec_d = '0;
          red_d = 1'b0;
        end else begin
          rec_d = (rec_q == '1) ? rec_q : rec_q + 1'b1;
        end
      end else begin
        rec_d = '0;
      end

      cnt_d = '0;
      shv_d = '0;
      wnv_d = '0;
      rdv_d = '0;
    end
    res_d.low_power      = low_d;
    res_d.supply_reduced = red_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      shv_q       <= '0;
      wnv_q       <= '0;
      rdv_q       <= '0;
      rec_q       <= '0;
      dly_q       <= '0;
      phase_q     <= wbm_pkg::PH_NONE;
      sent_q      <= 1'b0;
      red_q       <= 1'b0;
      low_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        cnt_q   <= cnt_d;
        shv_q   <= shv_d;
        wnv_q   <= wnv_d;
        rdv_q   <= rdv_d;
        rec_q   <= rec_d;
        dly_q   <= dly_d;
        phase_q <= phase_d;
        sent_q  <= sent_d;
        red_q   <= red_d;
        low_q   <= low_d;
      end
      if (item_pop_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== sv/windowed_battery_monitor.sv =====
// ----------------------------------------------------------------------------
// windowed_battery_monitor
// Windowed majority vote on battery samples: low power, shutdown/warning
// requests and reduced supply control.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per battery sample (tdata[7:0] level, tdata[8] queue
//     ready flag). m_axis: exactly one result per sample, in order.
//   cfg: write enable, register index and data; registers take effect for
//     samples accepted after the write. Write only while the block is idle.
// Path: a sample accepted on s_axis is written into the classify queue, then
//   the window engine pops it and registers the result; a held result
//   register keeps it waiting in the queue.
// Throughput: one sample per cycle while m_axis_tready is high, set by
//   the window engine, which updates all counters and requests together.
// Stall: when m_axis_tready is low the result register holds and the
//   two-entry queue fills; s_axis_tready drops once the queue is full.
// Reset: counters, phase, flags and queue clear; configuration registers
//   return to their defaults (window 100, levels 32/33/35, recover 5,
//   delay 14). No clearing pass is needed.
// ----------------------------------------------------------------------------
module windowed_battery_monitor #(
  parameter int unsigned COUNT_WIDTH = wbm_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] battery_level, [8] queue_ready, [15:9] zero
  input  logic [wbm_pkg::InTdataW-1:0]     s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] window_done, [1] low_power, [2] shutdown_request,
  // [3] warning_request, [4] supply_reduced, [7:5] zero
  output logic [wbm_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  input  logic                             cfg_we_i,
  input  logic [wbm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wbm_pkg::WinW-1:0]         cfg_data_i
);

  wbm_pkg::cfg_t    cfg_q;
  wbm_pkg::item_t   front_item, back_item;
  wbm_pkg::result_t result;
  logic             q_not_empty, q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len      <= wbm_pkg::WindowLenRst;
      cfg_q.shutdown_level  <= wbm_pkg::ShutdownLevelRst;
      cfg_q.warn_level      <= wbm_pkg::WarnLevelRst;
      cfg_q.reduce_level    <= wbm_pkg::ReduceLevelRst;
      cfg_q.recover_windows <= wbm_pkg::RecoverWindowsRst;
      cfg_q.powerdown_delay <= wbm_pkg::PowerdownDelayRst;
    end else if (cfg_we_i) begin
      case (wbm_pkg::reg_idx_e'(cfg_idx_i))
        wbm_pkg::REG_WINDOW_LEN:      cfg_q.window_len      <= cfg_data_i;
        wbm_pkg::REG_SHUTDOWN_LEVEL:  cfg_q.shutdown_level  <= cfg_data_i[wbm_pkg::LvlW-1:0];
        wbm_pkg::REG_WARN_LEVEL:      cfg_q.warn_level      <= cfg_data_i[wbm_pkg::LvlW-1:0];
        wbm_pkg::REG_REDUCE_LEVEL:    cfg_q.reduce_level    <= cfg_data_i[wbm_pkg::LvlW-1:0];
        wbm_pkg::REG_RECOVER_WINDOWS: cfg_q.recover_windows <= cfg_data_i[wbm_pkg::LvlW-1:0];
        wbm_pkg::REG_POWERDOWN_DELAY: cfg_q.powerdown_delay <= cfg_data_i[wbm_pkg::LvlW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // front: classify sample against levels
  wbm_front u_front (
    .battery_level_i (s_axis_tdata_i[wbm_pkg::LvlW-1:0]),
    .queue_ready_i   (s_axis_tdata_i[wbm_pkg::LvlW]),
    .cfg_i           (cfg_q),
    .item_o          (front_item)
  );

  // decoupling queue
  wbm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_item),
    .not_full_o  (s_axis_tready_o),
    .pop_i       (q_pop),
    .pop_data_o  (back_item),
    .not_empty_o (q_not_empty)
  );

  // back: window engine and result register
  wbm_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_not_empty),
    .item_i       (back_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_o        (result),
    .res_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = wbm_pkg::OutTdataW'(result);

`ifndef SYNTH
  // a popped sample always shows up as a result next cycle
  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> m_axis_tvalid_o)
    else $error("popped sample produced no result");

  // input stalls only while the queue holds work
  a_stall_means_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_not_empty)
    else $error("input stalled with empty queue");

  // requests are only issued on a window close
  a_request_on_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (result.shutdown_request || result.warning_request)
      |-> result.window_done)
    else $error("request outside a window close");
`endif

endmodule
